// ===== rtl/ohlc_pkg.sv =====
// ohlc_pkg: shared widths, item and bar types and register map
// for the ohlc bar aggregator; no dependencies
package ohlc_pkg;

    localparam int TimeW      = 48;
    localparam int EndW       = 49;
    localparam int PriceW     = 32;
    localparam int WidthW     = 32;
    localparam int ApbDataW   = 32;
    localparam int ApbAddrW   = 2;
    localparam int QueueDepth = 2;
    localparam int StepW      = $clog2(TimeW);

    localparam logic [ApbAddrW-1:0] AddrBarWidth  = 2'd0;
    localparam logic [WidthW-1:0]   BarWidthReset = 32'd1;

    typedef struct packed {
        logic [TimeW-1:0]         event_time;
        logic                     is_mid;
        logic signed [PriceW-1:0] price;
        logic                     series_end;
    } t_item;

    typedef struct packed {
        logic [TimeW-1:0]         bar_start;
        logic [EndW-1:0]          bar_end;
        logic signed [PriceW-1:0] open_price;
        logic signed [PriceW-1:0] high_price;
        logic signed [PriceW-1:0] low_price;
        logic signed [PriceW-1:0] close_price;
        logic                     final_bar;
    } t_bar;

endpackage

// ===== rtl/ohlc_if.sv =====
// ohlc_in_if and ohlc_out_if: valid/ready channels for events and bars
// depends on ohlc_pkg
interface ohlc_in_if;
    import ohlc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TimeW-1:0]         event_time;
    logic                     is_mid;
    logic signed [PriceW-1:0] price;
    logic                     series_end;

    modport source (output valid, event_time, is_mid, price, series_end, input ready);
    modport sink   (input valid, event_time, is_mid, price, series_end, output ready);
endinterface

interface ohlc_out_if;
    import ohlc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TimeW-1:0]         bar_start;
    logic [EndW-1:0]          bar_end;
    logic signed [PriceW-1:0] open_price;
    logic signed [PriceW-1:0] high_price;
    logic signed [PriceW-1:0] low_price;
    logic signed [PriceW-1:0] close_price;
    logic                     final_bar;

    modport source (output valid, bar_start, bar_end, open_price, high_price, low_price,
                    close_price, final_bar, input ready);
    modport sink   (input valid, bar_start, bar_end, open_price, high_price, low_price,
                    close_price, final_bar, output ready);
endinterface

// ===== rtl/ohlc_bar_aggregator_top.sv =====
// OHLC time-bar aggregator. Event beats enter on i_in and are queued; only
// mid-price events and series-end marks reach the bar logic. A mid event that
// lands in the pending window is binned in S_EVAL without the divider. An
// event that opens a new window, or the first one after the window width was
// rewritten, runs the bit-serial remainder unit, one bit of the 48-bit
// timestamp per cycle; an emitted bar also waits for the single-entry output
// register to drain. Bar beats leave on o_out, the previous bar first and then
// the final bar when one event both changes window and ends the series. The
// window width register sits at APB byte address 0 (reset 1, zero suppresses
// all bars); the user must write it only while idle, which the block itself
// does not enforce.
// depends on ohlc_pkg, ohlc_if, ohlc_front, ohlc_back, ohlc_rem_div
module ohlc_bar_aggregator_top #(
    parameter int QUEUE_DEPTH = ohlc_pkg::QueueDepth
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [ohlc_pkg::ApbAddrW-1:0]  i_paddr,
    input  logic [ohlc_pkg::ApbDataW-1:0]  i_pwdata,
    output logic [ohlc_pkg::ApbDataW-1:0]  o_prdata,
    output logic                           o_pready,
    ohlc_in_if.sink                        i_in,
    ohlc_out_if.source                     o_out
);
    import ohlc_pkg::*;

    logic [WidthW-1:0] r_win_width;
    logic              cfg_wr;
    t_item             head;
    logic              head_valid;
    logic              pop;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && (i_paddr == AddrBarWidth);
    assign o_prdata = (i_paddr == AddrBarWidth) ? r_win_width : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_width <= BarWidthReset;
        end else if (cfg_wr) begin
            r_win_width <= i_pwdata;
        end
    end

    ohlc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_win_width  (r_win_width),
        .i_in         (i_in),
        .o_head       (head),
        .i_pop        (pop),
        .o_head_valid (head_valid)
    );

    ohlc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_win_width  (r_win_width),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// ===== rtl/ohlc_front.sv =====
// ohlc_front: accepts event beats, drops events that cannot matter and
// queues the rest for the back end; depends on ohlc_pkg, ohlc_in_if
module ohlc_front #(
    parameter int QUEUE_DEPTH = ohlc_pkg::QueueDepth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ohlc_pkg::WidthW-1:0]  i_win_width,
    ohlc_in_if.sink                      i_in,
    output ohlc_pkg::t_item              o_head,
    input  logic                         i_pop,
    output logic                         o_head_valid
);
    import ohlc_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]   r_count, n_count;
    logic              accept;
    logic              keep;
    logic              push;
    logic              pop;
    logic              mid_eff;
    t_item             w_item;

    function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
        if (p == PtrW'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // mid events are meaningless while the width is zero
    assign mid_eff = i_in.is_mid && (i_win_width != '0);
    assign keep    = mid_eff || i_in.series_end;

    assign i_in.ready = (r_count != CntW'(QUEUE_DEPTH));
    assign accept     = i_in.valid && i_in.ready;
    assign push       = accept && keep;
    assign pop        = i_pop && (r_count != '0);

    assign w_item.event_time = i_in.event_time;
    assign w_item.is_mid     = mid_eff;
    assign w_item.price      = i_in.price;
    assign w_item.series_end = i_in.series_end;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_head_valid = (r_count != '0);

    always_comb begin
        n_wr_ptr = push ? wrap_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = pop ? wrap_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

// ===== rtl/ohlc_rem_div.sv =====
// ohlc_rem_div: restoring divider, one quotient bit per cycle, that
// returns event_time modulo bar_width; depends on ohlc_pkg
module ohlc_rem_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ohlc_pkg::TimeW-1:0]   i_dividend,
    input  logic [ohlc_pkg::WidthW-1:0]  i_divisor,
    output logic                         o_done,
    output logic [ohlc_pkg::WidthW-1:0]  o_rem
);
    import ohlc_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [StepW-1:0]    r_cnt;
    logic [TimeW-1:0]    r_dvd;
    logic [WidthW-1:0]   r_dvs;
    logic [WidthW-1:0]   r_rem, n_rem;
    logic [WidthW:0]     partial;
    logic [WidthW:0]     diff;

    assign partial = {r_rem, r_dvd[TimeW-1]};
    assign diff    = partial - {1'b0, r_dvs};
    assign n_rem   = diff[WidthW] ? partial[WidthW-1:0] : diff[WidthW-1:0];

    assign o_done = r_done;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= StepW'(TimeW - 1);
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_dvd <= {r_dvd[TimeW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

endmodule

// ===== rtl/ohlc_back.sv =====
// ohlc_back: bins queued events, keeps the pending bar and drives the
// bar output register; depends on ohlc_pkg, ohlc_out_if, ohlc_rem_div
module ohlc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ohlc_pkg::WidthW-1:0]  i_win_width,
    input  ohlc_pkg::t_item              i_head,
    input  logic                         i_head_valid,
    output logic                         o_pop,
    ohlc_out_if.source                   o_out
);
    import ohlc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_BIN  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_END  = 3'd5;

    logic [2:0]               r_state, n_state;
    t_item                    r_item;
    logic                     r_open, n_open;
    logic [TimeW-1:0]         r_ws;
    logic [WidthW-1:0]        r_bin_width;
    logic [TimeW-1:0]         r_new_ws;
    logic signed [PriceW-1:0] r_open_p, r_high, r_low, r_close;
    logic                     r_out_valid;
    t_bar                     r_out;

    logic                     out_free;
    logic                     load_out;
    logic                     load_final;
    logic                     do_update;
    logic                     do_start;
    logic [TimeW-1:0]         start_ws;
    logic                     div_start;
    logic                     div_done;
    logic [WidthW-1:0]        div_rem;
    logic [TimeW:0]           time_diff;
    logic                     in_win;
    logic [2:0]               after_state;
    t_bar                     w_bar;

    ohlc_rem_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_item.event_time),
        .i_divisor  (i_win_width),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // fast path only while the pending window was binned with the current width
    assign out_free  = !r_out_valid || o_out.ready;
    assign time_diff = {1'b0, r_item.event_time} - {1'b0, r_ws};
    assign in_win    = r_open && (r_bin_width == i_win_width) && !time_diff[TimeW]
                       && (time_diff[TimeW-1:0] < {{(TimeW-WidthW){1'b0}}, i_win_width});
    assign after_state = r_item.series_end ? S_END : S_IDLE;

    always_comb begin
        w_bar.bar_start   = r_ws;
        w_bar.bar_end     = {1'b0, r_ws} + {{(EndW-WidthW){1'b0}}, i_win_width};
        w_bar.open_price  = r_open_p;
        w_bar.high_price  = r_high;
        w_bar.low_price   = r_low;
        w_bar.close_price = r_close;
        w_bar.final_bar   = load_final;
    end

    always_comb begin
        n_state    = r_state;
        n_open     = r_open;
        o_pop      = 1'b0;
        load_out   = 1'b0;
        load_final = 1'b0;
        do_update  = 1'b0;
        do_start   = 1'b0;
        start_ws   = r_new_ws;
        div_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop   = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_item.is_mid) begin
                    if (in_win) begin
                        do_update = 1'b1;
                        n_state   = after_state;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end else begin
                    n_state = S_END;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_BIN;
                end
            end
            S_BIN: begin
                if (!r_open) begin
                    do_start = 1'b1;
                    n_open   = 1'b1;
                    n_state  = after_state;
                end else if (r_new_ws != r_ws) begin
                    n_state = S_EMIT;
                end else begin
                    do_update = 1'b1;
                    n_state   = after_state;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    do_start = 1'b1;
                    n_state  = after_state;
                end
            end
            S_END: begin
                if (r_open && (i_win_width != '0)) begin
                    if (out_free) begin
                        load_out   = 1'b1;
                        load_final = 1'b1;
                        n_open     = 1'b0;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_open  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
        if (div_done) begin
            r_new_ws <= r_item.event_time - {{(TimeW-WidthW){1'b0}}, div_rem};
        end
        if (load_out) begin
            r_out <= w_bar;
        end
        if (do_start || do_update) begin
            r_bin_width <= i_win_width;
        end
        if (do_start) begin
            r_ws     <= start_ws;
            r_open_p <= r_item.price;
            r_high   <= r_item.price;
            r_low    <= r_item.price;
            r_close  <= r_item.price;
        end else if (do_update) begin
            if (r_item.price > r_high) begin
                r_high <= r_item.price;
            end
            if (r_item.price < r_low) begin
                r_low <= r_item.price;
            end
            r_close <= r_item.price;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.bar_start   = r_out.bar_start;
    assign o_out.bar_end     = r_out.bar_end;
    assign o_out.open_price  = r_out.open_price;
    assign o_out.high_price  = r_out.high_price;
    assign o_out.low_price   = r_out.low_price;
    assign o_out.close_price = r_out.close_price;
    assign o_out.final_bar   = r_out.final_bar;

endmodule

// ===== rtl/ohlc_checker.sv =====
// ohlc_checker: port-level checks on bar beats of the aggregator top
// bound to ohlc_bar_aggregator_top; depends on ohlc_pkg
module ohlc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 i_ready,
    input logic [ohlc_pkg::TimeW-1:0]           i_bar_start,
    input logic signed [ohlc_pkg::PriceW-1:0]   i_open_price,
    input logic signed [ohlc_pkg::PriceW-1:0]   i_high_price,
    input logic signed [ohlc_pkg::PriceW-1:0]   i_low_price,
    input logic signed [ohlc_pkg::PriceW-1:0]   i_close_price
);
    import ohlc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_bar_start) && $stable(i_close_price))
        else $error("bar beat changed while stalled");

    a_high_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_high_price >= i_low_price)
        else $error("bar high below low");

    a_open_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_open_price <= i_high_price && i_open_price >= i_low_price)
        else $error("bar open outside high/low");

    a_close_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_close_price <= i_high_price && i_close_price >= i_low_price)
        else $error("bar close outside high/low");

endmodule

bind ohlc_bar_aggregator_top ohlc_checker u_ohlc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_bar_start   (o_out.bar_start),
    .i_open_price  (o_out.open_price),
    .i_high_price  (o_out.high_price),
    .i_low_price   (o_out.low_price),
    .i_close_price (o_out.close_price)
);

// ===== tb/ohlc_bar_aggregator_top_test.sv =====
`timescale 1ns / 1ps
// ohlc_bar_aggregator_top_test: checks the ohlc bar aggregator against an in-bench
// bar predictor with directed cases and random event series under random backpressure
// depends on ohlc_pkg, ohlc_if, ohlc_bar_aggregator_top
module ohlc_bar_aggregator_top_test;
    import ohlc_pkg::*;

    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles   = 200;
    localparam logic [TimeW-1:0]  MaxTime  = {TimeW{1'b1}};
    localparam logic [PriceW-1:0] PriceMax = 32'h7FFF_FFFF;
    localparam logic [PriceW-1:0] PriceMin = 32'h8000_0000;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    ohlc_in_if  evt_if ();
    ohlc_out_if bar_if ();

    ohlc_bar_aggregator_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_psel   (psel),
        .i_penable(penable),
        .i_pwrite (pwrite),
        .i_paddr  (paddr),
        .i_pwdata (pwdata),
        .o_prdata (prdata),
        .o_pready (pready),
        .i_in     (evt_if),
        .o_out    (bar_if)
    );

    // bar predictor state
    logic [WidthW-1:0]        cur_width;
    bit                       bar_pending;
    logic [TimeW-1:0]         win_start;
    logic signed [PriceW-1:0] bar_open;
    logic signed [PriceW-1:0] bar_high;
    logic signed [PriceW-1:0] bar_low;
    logic signed [PriceW-1:0] bar_close;
    t_bar                     bars_due[$];

    int err_count;
    int idle_cycles;
    int n_events;
    int n_bars;
    int n_final;
    int n_widths;
    int snd_idle_pct;
    int rcv_stall_pct;

    function automatic void clear_bar_state();
        bar_pending = 1'b0;
        win_start   = '0;
        bar_open    = '0;
        bar_high    = '0;
        bar_low     = '0;
        bar_close   = '0;
    endfunction

    function automatic t_bar make_bar(logic fin);
        t_bar b;
        b.bar_start   = win_start;
        b.bar_end     = EndW'(win_start) + EndW'(cur_width);
        b.open_price  = bar_open;
        b.high_price  = bar_high;
        b.low_price   = bar_low;
        b.close_price = bar_close;
        b.final_bar   = fin;
        return b;
    endfunction

    function automatic void bin_event(t_item it);
        logic [TimeW-1:0] ws;
        logic signed [PriceW-1:0] p;
        p = $signed(it.price);
        if (it.is_mid && cur_width != '0) begin
            ws = it.event_time - (it.event_time % TimeW'(cur_width));
            if (bar_pending && ws != win_start) begin
                bars_due = {bars_due, make_bar(1'b0)};
            end
            if (!bar_pending || ws != win_start) begin
                bar_pending = 1'b1;
                win_start   = ws;
                bar_open    = p;
                bar_high    = p;
                bar_low     = p;
                bar_close   = p;
            end else begin
                if (p > bar_high) bar_high = p;
                if (p < bar_low) bar_low = p;
                bar_close = p;
            end
        end
        if (it.series_end) begin
            if (bar_pending && cur_width != '0) begin
                bars_due = {bars_due, make_bar(1'b1)};
            end
            clear_bar_state();
        end
    endfunction

    function automatic string bar_str(t_bar b);
        return $sformatf("[%0d,%0d) o=%0d h=%0d l=%0d c=%0d final=%0b",
                         b.bar_start, b.bar_end, $signed(b.open_price),
                         $signed(b.high_price), $signed(b.low_price),
                         $signed(b.close_price), b.final_bar);
    endfunction

    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR at %0t ns: %s", $time, msg);
    endfunction

    function automatic void check_bar(t_bar got);
        t_bar  want;
        string diff;
        diff = "";
        if (bars_due.size() == 0) begin
            note_error({"bar with none expected: ", bar_str(got)});
        end else begin
            want = bars_due.pop_front();
            if (got.bar_start !== want.bar_start) diff = {diff, " bar_start"};
            if (got.bar_end !== want.bar_end) diff = {diff, " bar_end"};
            if (got.open_price !== want.open_price) diff = {diff, " open"};
            if (got.high_price !== want.high_price) diff = {diff, " high"};
            if (got.low_price !== want.low_price) diff = {diff, " low"};
            if (got.close_price !== want.close_price) diff = {diff, " close"};
            if (got.final_bar !== want.final_bar) diff = {diff, " final_bar"};
            if (diff != "") begin
                note_error({"bar mismatch in", diff, ": expected ", bar_str(want),
                            " got ", bar_str(got)});
            end
            n_bars++;
            if (want.final_bar) n_final++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        bar_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            bar_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // predicts on every event beat, checks every bar beat, guards against a hang
    always @(posedge i_clk) begin : monitor
        t_item it;
        t_bar  got;
        if (i_rst_n) begin
            idle_cycles++;
            if (evt_if.valid && evt_if.ready) begin
                it.event_time = evt_if.event_time;
                it.is_mid     = evt_if.is_mid;
                it.price      = evt_if.price;
                it.series_end = evt_if.series_end;
                bin_event(it);
                n_events++;
                idle_cycles = 0;
            end
            if (bar_if.valid && bar_if.ready) begin
                got.bar_start   = bar_if.bar_start;
                got.bar_end     = bar_if.bar_end;
                got.open_price  = bar_if.open_price;
                got.high_price  = bar_if.high_price;
                got.low_price   = bar_if.low_price;
                got.close_price = bar_if.close_price;
                got.final_bar   = bar_if.final_bar;
                check_bar(got);
                idle_cycles = 0;
            end
            if (idle_cycles >= WatchdogLimit) begin
                $display("timeout: no beat for %0d cycles, %0d bars outstanding",
                         idle_cycles, bars_due.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_event(logic [TimeW-1:0] t, logic mid, logic [PriceW-1:0] p,
                              logic fin);
        while ($urandom_range(99) < snd_idle_pct) begin
            evt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        evt_if.valid      <= 1'b1;
        evt_if.event_time <= t;
        evt_if.is_mid     <= mid;
        evt_if.price      <= p;
        evt_if.series_end <= fin;
        do @(posedge i_clk); while (!evt_if.ready);
    endtask

    task automatic wait_idle();
        evt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (bars_due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // write then read back, back to back with psel held
    task automatic set_win_width(logic [WidthW-1:0] w);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrBarWidth;
        pwdata  <= w;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cur_width = w;
        n_widths++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== w) begin
            note_error($sformatf("window width read back 0x%08h, wrote 0x%08h", prdata, w));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_window_rollover();
        send_event(48'd0, 1'b1, 32'd5, 1'b0);
        send_event(48'd0, 1'b1, -32'sd3, 1'b0);
        send_event(48'd0, 1'b0, 32'd100, 1'b0);
        send_event(48'd0, 1'b1, 32'd9, 1'b0);
        send_event(48'd1, 1'b1, 32'd7, 1'b0);
        // new window and series end on one beat: two bars
        send_event(48'd5, 1'b1, 32'd2, 1'b1);
        // series end with nothing pending
        send_event(48'd6, 1'b0, 32'd0, 1'b1);
    endtask

    task automatic test_field_extremes();
        set_win_width(32'hFFFF_FFFF);
        send_event(48'd0, 1'b1, PriceMax, 1'b0);
        send_event(48'd1, 1'b1, PriceMin, 1'b0);
        send_event(MaxTime, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send_event(MaxTime, 1'b0, PriceMax, 1'b1);
    endtask

    task automatic test_time_backwards();
        set_win_width(32'd10);
        send_event(48'd100, 1'b1, 32'd1, 1'b0);
        send_event(48'd55, 1'b1, 32'd2, 1'b0);
        send_event(48'd57, 1'b1, 32'd3, 1'b1);
    endtask

    task automatic test_width_change();
        send_event(48'd23, 1'b1, 32'd4, 1'b0);
        set_win_width(32'd7);
        send_event(48'd24, 1'b1, 32'd6, 1'b0);
    endtask

    task automatic test_zero_width();
        // pending bar from the width change is dropped
        set_win_width(32'd0);
        send_event(48'd30, 1'b1, 32'd8, 1'b0);
        send_event(48'd31, 1'b0, 32'd9, 1'b1);
        set_win_width(32'd3);
        send_event(48'd31, 1'b1, 32'd1, 1'b1);
    endtask

    task automatic test_random_series(int n_items, logic [WidthW-1:0] w);
        int          sent;
        int          len;
        int          r;
        logic [63:0] t;
        logic [63:0] dt;
        logic [63:0] w64;
        logic [PriceW-1:0] p;
        set_win_width(w);
        w64  = 64'(w);
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 24);
            if ($urandom_range(1) == 0) t = {$urandom_range(0, 16'hFFFF), $urandom};
            else t = (w64 == 0 ? 64'd1 : w64) * $urandom_range(0, 1000);
            p = $urandom;
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(99);
                if (r < 35) begin
                    dt = 0;
                end else if (r < 70) begin
                    dt = (w64 > 1) ? 64'($urandom_range(w - 1)) : 64'd0;
                end else if (r < 95) begin
                    dt = (w64 == 0) ? 64'($urandom_range(1, 50))
                                    : w64 * $urandom_range(1, 3) + $urandom_range(0, 3);
                end else begin
                    // broken order: step back two or three windows, or to time zero
                    dt = 0;
                    t  = (t > 2 * w64 + 1) ? t - (2 * w64 + 1) : 64'd0;
                end
                t = t + dt;
                if (t > 64'(MaxTime)) t = 64'(MaxTime);
                r = $urandom_range(99);
                case (r % 4)
                    0: p = (r < 8) ? PriceMax : $urandom;
                    1: p = (r < 8) ? PriceMin : $urandom;
                    2: p = (r < 8) ? 32'd0 : p + $urandom_range(0, 20) - 10;
                    default: p = (r < 8) ? 32'hFFFF_FFFF : p + $urandom_range(0, 20) - 10;
                endcase
                send_event(t[TimeW-1:0], $urandom_range(99) < 85, p, k == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        logic [WidthW-1:0] widths [6];
        int                counts [6];
        err_count     = 0;
        idle_cycles   = 0;
        n_events      = 0;
        n_bars        = 0;
        n_final       = 0;
        n_widths      = 0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        cur_width     = BarWidthReset;
        clear_bar_state();
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        evt_if.valid      <= 1'b0;
        evt_if.event_time <= '0;
        evt_if.is_mid     <= 1'b0;
        evt_if.price      <= '0;
        evt_if.series_end <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_window_rollover();
        test_field_extremes();
        test_time_backwards();
        test_width_change();
        test_zero_width();

        widths = '{32'd1, 32'($urandom_range(2, 40)), 32'hFFFF_FFFF, 32'd0,
                   32'($urandom), 32'($urandom_range(2, 40))};
        counts = '{170, 170, 170, 40, 170, 180};
        for (int s = 0; s < 6; s++) begin
            wait_idle();
            case (s % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 73; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 73; end
                default: begin snd_idle_pct = 22; rcv_stall_pct = 22; end
            endcase
            test_random_series(counts[s], widths[s]);
        end

        wait_idle();
        $display("covered %0d event beats over %0d window width settings", n_events,
                 n_widths);
        $display("checked %0d bars, %0d of them final, %0d errors", n_bars, n_final,
                 err_count);
        if (err_count == 0 && bars_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
